/* rtl/core/seh_pkg.sv */
// ----------------------------------------------------------------------------
// seh_pkg
// Shared types and codes for the endstop homing sequencer.
// ----------------------------------------------------------------------------
package seh_pkg;

   // Configuration register width and indexes
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_ENDSTOP_PRESENT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_APPROACH_LIMIT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRACT_STEPS   = 2'd2;

   // Configuration reset values
   localparam logic                  RST_ENDSTOP_PRESENT = 1'b1;
   localparam logic [CSR_DATA_W-1:0] RST_APPROACH_LIMIT  = 16'd1000;
   localparam logic [CSR_DATA_W-1:0] RST_RETRACT_STEPS   = 16'd100;

   // Request codes
   localparam logic REQ_TICK  = 1'b0;
   localparam logic REQ_START = 1'b1;

   // Step direction codes
   localparam logic DIR_TOWARD = 1'b0;
   localparam logic DIR_AWAY   = 1'b1;

   // Homing status codes
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_BUSY = 2'd1;
   localparam logic [1:0] ST_OK   = 2'd2;
   localparam logic [1:0] ST_FAIL = 2'd3;

   // Sequencer phase
   typedef enum logic [2:0] {
      PH_IDLE     = 3'b001,
      PH_RETRACT  = 3'b010,
      PH_APPROACH = 3'b100
   } phase_type;

   // Live configuration
   typedef struct packed {
      logic                  endstop_present;
      logic [CSR_DATA_W-1:0] approach_limit;
      logic [CSR_DATA_W-1:0] retract_steps;
   } cfg_type;

   // One result item
   typedef struct packed {
      logic       step_valid;
      logic       step_dir;
      logic [1:0] home_status;
   } rsp_type;

endpackage

/* rtl/core/stepper_endstop_homing.sv */
// ----------------------------------------------------------------------------
// stepper_endstop_homing
// Double-touch endstop homing sequencer with registered input and output.
// ----------------------------------------------------------------------------
// Each item is a tick or a start command plus the sampled endstop level; each
// gives exactly one result (step request, direction, homing status). Items
// pass an input register, the sequencer logic and a result register: rsp_valid
// rises when the result register is loaded from the input register, which a
// stall on the result channel can hold up, and one item is taken every cycle
// while rsp_stall is low. While a finished result waits in the output
// register, the input register can still take one more item and then stalls.
// Configuration writes take effect on the next cycle; there is no clearing
// pass after reset. COUNT_WIDTH sets the width of the step counter.
module stepper_endstop_homing #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_type,
   input  logic                             req_endstop_pressed,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_step_valid,
   output logic                             rsp_step_dir,
   output logic [1:0]                       rsp_home_status,
   // configuration
   input  logic                             csr_wr_en,
   input  logic [seh_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [seh_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   seh_pkg::cfg_type cfg;
   seh_pkg::rsp_type seq_rsp;

   logic             in_valid_ff, in_valid_in;
   logic             in_type_ff;
   logic             in_pressed_ff;
   logic             out_valid_ff, out_valid_in;
   seh_pkg::rsp_type out_ff;

   logic             out_free;
   logic             proc;
   logic             req_take;

   seh_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   seh_seq #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .advance         (proc),
      .req_type        (in_type_ff),
      .endstop_pressed (in_pressed_ff),
      .cfg             (cfg),
      .rsp             (seq_rsp)
   );

   // Pipeline flow control
   assign out_free    = !out_valid_ff || !rsp_stall;
   assign proc        = in_valid_ff && out_free;
   assign req_stall   = in_valid_ff && !proc;
   assign req_take    = req_valid && !req_stall;
   assign in_valid_in = req_take || (in_valid_ff && !proc);
   assign out_valid_in = proc || (out_valid_ff && rsp_stall);

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_type_ff    <= req_type;
         in_pressed_ff <= req_endstop_pressed;
      end
      if (proc) begin
         out_ff <= seq_rsp;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_step_valid  = out_ff.step_valid;
   assign rsp_step_dir    = out_ff.step_dir;
   assign rsp_home_status = out_ff.home_status;

endmodule

/* rtl/core/seh_csr.sv */
// ----------------------------------------------------------------------------
// seh_csr
// Configuration registers written through the plain write port.
// ----------------------------------------------------------------------------
module seh_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [seh_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [seh_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output seh_pkg::cfg_type                 cfg
);

   seh_pkg::cfg_type cfg_ff;
   seh_pkg::cfg_type cfg_in;

   // Register decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            seh_pkg::CSR_ENDSTOP_PRESENT: cfg_in.endstop_present = csr_wdata[0];
            seh_pkg::CSR_APPROACH_LIMIT:  cfg_in.approach_limit  = csr_wdata;
            seh_pkg::CSR_RETRACT_STEPS:   cfg_in.retract_steps   = csr_wdata;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.endstop_present <= seh_pkg::RST_ENDSTOP_PRESENT;
         cfg_ff.approach_limit  <= seh_pkg::RST_APPROACH_LIMIT;
         cfg_ff.retract_steps   <= seh_pkg::RST_RETRACT_STEPS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/core/seh_seq.sv */
// ----------------------------------------------------------------------------
// seh_seq
// Homing state machine: phase, touch count, step count and stored outcome.
// Computes the result of one item and updates state when it is processed.
// ----------------------------------------------------------------------------
module seh_seq #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              req_type,
   input  logic              endstop_pressed,
   input  seh_pkg::cfg_type  cfg,
   output seh_pkg::rsp_type  rsp
);

   localparam int CMP_W = (COUNT_WIDTH > seh_pkg::CSR_DATA_W) ?
                          COUNT_WIDTH : seh_pkg::CSR_DATA_W;

   seh_pkg::phase_type     phase_ff, phase_in;
   logic [1:0]             touch_ff, touch_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [1:0]             outcome_ff, outcome_in;

   logic [CMP_W-1:0]       count_ext;
   logic                   count_sat;
   logic                   retract_more;
   logic                   approach_more;
   logic [1:0]             touch_inc;

   // Budget compares; a saturated counter counts as exhausted
   assign count_ext     = CMP_W'(count_ff);
   assign count_sat     = (count_ff == {COUNT_WIDTH{1'b1}});
   assign retract_more  = (count_ext < CMP_W'(cfg.retract_steps)) && !count_sat;
   assign approach_more = (count_ext < CMP_W'(cfg.approach_limit)) && !count_sat;
   assign touch_inc     = touch_ff + 2'd1;

   // Next state and result
   always_comb begin
      phase_in        = phase_ff;
      touch_in        = touch_ff;
      count_in        = count_ff;
      outcome_in      = outcome_ff;
      rsp.step_valid  = 1'b0;
      rsp.step_dir    = seh_pkg::DIR_TOWARD;

      if (req_type == seh_pkg::REQ_START) begin
         count_in = '0;
         if (!cfg.endstop_present) begin
            outcome_in = seh_pkg::ST_OK;
            phase_in   = seh_pkg::PH_IDLE;
         end else if (endstop_pressed) begin
            touch_in = 2'd1;
            phase_in = seh_pkg::PH_RETRACT;
         end else begin
            touch_in = 2'd0;
            phase_in = seh_pkg::PH_APPROACH;
         end
      end else begin
         unique case (phase_ff)
            seh_pkg::PH_RETRACT: begin
               if (retract_more) begin
                  rsp.step_valid = 1'b1;
                  rsp.step_dir   = seh_pkg::DIR_AWAY;
                  count_in       = count_ff + COUNT_WIDTH'(1);
               end else if (endstop_pressed) begin
                  outcome_in = seh_pkg::ST_FAIL;
                  phase_in   = seh_pkg::PH_IDLE;
                  count_in   = '0;
               end else begin
                  phase_in = seh_pkg::PH_APPROACH;
                  count_in = '0;
               end
            end
            seh_pkg::PH_APPROACH: begin
               if (endstop_pressed) begin
                  touch_in = touch_inc;
                  count_in = '0;
                  // second touch ends the sequence
                  if (touch_inc >= 2'd2) begin
                     outcome_in = seh_pkg::ST_OK;
                     phase_in   = seh_pkg::PH_IDLE;
                  end else begin
                     phase_in = seh_pkg::PH_RETRACT;
                  end
               end else if (approach_more) begin
                  rsp.step_valid = 1'b1;
                  rsp.step_dir   = seh_pkg::DIR_TOWARD;
                  count_in       = count_ff + COUNT_WIDTH'(1);
               end else begin
                  outcome_in = seh_pkg::ST_FAIL;
                  phase_in   = seh_pkg::PH_IDLE;
                  count_in   = '0;
               end
            end
            default: begin
               phase_in = seh_pkg::PH_IDLE;
            end
         endcase
      end

      rsp.home_status = (phase_in == seh_pkg::PH_IDLE) ? outcome_in : seh_pkg::ST_BUSY;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= seh_pkg::PH_IDLE;
         touch_ff   <= 2'd0;
         count_ff   <= '0;
         outcome_ff <= seh_pkg::ST_IDLE;
      end else if (advance) begin
         phase_ff   <= phase_in;
         touch_ff   <= touch_in;
         count_ff   <= count_in;
         outcome_ff <= outcome_in;
      end
   end

endmodule
